### src/cart_pkg.sv
// ----------------------------------------------------------------------------
// cart_pkg
// Shared types and codes of the command ack retry table.
// ----------------------------------------------------------------------------
package cart_pkg;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;

	localparam logic [3:0] K_TRACKED   = 4'd0;
	localparam logic [3:0] K_UNTRACKED = 4'd1;
	localparam logic [3:0] K_REJECTED  = 4'd2;
	localparam logic [3:0] K_FULL      = 4'd3;
	localparam logic [3:0] K_ACK_HIT   = 4'd4;
	localparam logic [3:0] K_ACK_MISS  = 4'd5;
	localparam logic [3:0] K_RETRY     = 4'd6;
	localparam logic [3:0] K_TIMEOUT   = 4'd7;
	localparam logic [3:0] K_IDLE      = 4'd8;

	localparam logic [2:0] R_ROBOT_COUNT = 3'd0;
	localparam logic [2:0] R_CRIT_PRIO   = 3'd1;
	localparam logic [2:0] R_TIMEOUT     = 3'd2;
	localparam logic [2:0] R_ESTOP       = 3'd3;
	localparam logic [2:0] R_STOP        = 3'd4;
	localparam logic [2:0] R_START       = 3'd5;
	localparam logic [2:0] R_CANCEL      = 3'd6;

	localparam int MAX_RESULTS = 16;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [47:0] now_us;
		logic [7:0]  robot_num;
		logic        address_known;
		logic [7:0]  command_type;
		logic [31:0] command_seq;
		logic [7:0]  priority_req;
		logic        wants_ack;
		logic [31:0] ack_command_id;
	} req_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  out_robot;
		logic [7:0]  out_type;
		logic [31:0] out_seq;
		logic [31:0] out_command_id;
		logic [1:0]  retries_remaining;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [7:0]  robot_count;
		logic [7:0]  critical_priority;
		logic [23:0] ack_timeout_us;
		logic [7:0]  estop_type_code;
		logic [7:0]  stop_type_code;
		logic [7:0]  start_type_code;
		logic [7:0]  cancel_type_code;
	} cfg_t;

	// command from controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic clr_idx;   // restart slot index
		logic step;      // advance slot index
		logic classify;  // poll: classify and update slot at index
		logic pass2;     // poll: second report pass (retries)
		logic do_send;   // resolve send
		logic commit;    // write slot at index (send)
		logic ack_free;  // free slot at index (ack)
		logic emit;      // load output register
		logic emit_kind; // emit from current slot with poll kind
		logic emit_last;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic idx_end;     // index on final slot
		logic free_here;   // slot at index is free
		logic ack_hit;     // slot at index matches ack
		logic timed_here;  // slot at index timed out this poll
		logic retry_here;  // slot at index retried this poll
		logic any_left;    // later report exists in this or next pass
		logic cap_full;    // result count reached cap
		logic [1:0] opcode;
		logic send_ok;     // valid robot and known address
		logic need_ack;
		logic ack_robot_ok;
	} sts_t;

endpackage

### src/cart_if.sv
// ----------------------------------------------------------------------------
// cart_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface cart_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/cart_datapath.sv
// ----------------------------------------------------------------------------
// cart_datapath
// Slot table, request register, slot index and output register.
// ----------------------------------------------------------------------------
module cart_datapath
	import cart_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t res
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	req_t req_q;
	logic [IW-1:0] idx_q;
	logic [SLOTS-1:0] busy_q, timed_q, retry_q;
	logic [31:0] next_id_q;
	logic [4:0] cnt_q;
	logic [7:0]  robot_m [SLOTS];
	logic [7:0]  type_m [SLOTS];
	logic [31:0] seq_m [SLOTS];
	logic [31:0] id_m [SLOTS];
	logic [47:0] dl_m [SLOTS];
	logic [1:0]  rt_m [SLOTS];
	logic [1:0]  grant_q;

	// saturating deadline
	logic [48:0] dl_sum;
	logic [47:0] dl_new;
	assign dl_sum = {1'b0, req_q.now_us} + {25'd0, cfg.ack_timeout_us};
	assign dl_new = dl_sum[48] ? '1 : dl_sum[47:0];

	logic expired;
	assign expired = busy_q[idx_q] && (req_q.now_us >= dl_m[idx_q]);

	// later reports after index in current pass, or any in retry pass
	logic [SLOTS-1:0] above;
	always_comb begin
		for (int i = 0; i < SLOTS; i++) above[i] = (i > int'(idx_q));
	end

	always_comb begin
		sts = '0;
		sts.idx_end = (int'(idx_q) == SLOTS - 1);
		sts.free_here = !busy_q[idx_q];
		sts.ack_hit = busy_q[idx_q] && robot_m[idx_q] == req_q.robot_num &&
			(seq_m[idx_q] == req_q.command_seq || id_m[idx_q] == req_q.ack_command_id);
		sts.timed_here = timed_q[idx_q];
		sts.retry_here = retry_q[idx_q];
		sts.any_left = cmd.pass2 ? |(retry_q & above) : (|(timed_q & above) || |retry_q);
		sts.cap_full = (cnt_q == 5'(MAX_RESULTS - 1));
		sts.opcode = req_q.opcode;
		sts.send_ok = (req_q.robot_num < cfg.robot_count) && req_q.address_known;
		sts.need_ack = req_q.wants_ack || req_q.command_type == cfg.estop_type_code ||
			req_q.command_type == cfg.stop_type_code ||
			req_q.command_type == cfg.start_type_code ||
			req_q.command_type == cfg.cancel_type_code;
		sts.ack_robot_ok = req_q.robot_num < cfg.robot_count;
	end

	// request capture and slot index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.step) idx_q <= idx_q + 1'b1;
			if (cmd.load) cnt_q <= '0;
			else if (cmd.emit) cnt_q <= cnt_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.do_send) grant_q <= (req_q.priority_req >= cfg.critical_priority) ? 2'd3 : 2'd1;
	end

	// busy bits, poll marks and id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			timed_q <= '0;
			retry_q <= '0;
			next_id_q <= 32'd1;
		end else begin
			if (cmd.load) begin
				timed_q <= '0;
				retry_q <= '0;
			end
			if (cmd.do_send) next_id_q <= next_id_q + 32'd1;
			if (cmd.commit) busy_q[idx_q] <= 1'b1;
			if (cmd.ack_free) busy_q[idx_q] <= 1'b0;
			// poll scan pass: classify and update one slot
			if (cmd.classify && expired) begin
				if (rt_m[idx_q] == 2'd0) begin
					timed_q[idx_q] <= 1'b1;
					busy_q[idx_q] <= 1'b0;
				end else begin
					retry_q[idx_q] <= 1'b1;
				end
			end
		end
	end

	// slot payload storage
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			robot_m[idx_q] <= req_q.robot_num;
			type_m[idx_q] <= req_q.command_type;
			seq_m[idx_q] <= req_q.command_seq;
			id_m[idx_q] <= next_id_q - 32'd1;
			dl_m[idx_q] <= dl_new;
			rt_m[idx_q] <= grant_q;
		end
		if (cmd.classify && expired && rt_m[idx_q] != 2'd0) begin
			rt_m[idx_q] <= rt_m[idx_q] - 2'd1;
			dl_m[idx_q] <= dl_new;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res.last <= cmd.emit_last;
			res.slot <= '0;
			res.out_robot <= req_q.robot_num;
			res.out_type <= req_q.command_type;
			res.out_seq <= req_q.command_seq;
			res.out_command_id <= '0;
			res.retries_remaining <= '0;
			if (cmd.emit_kind) begin
				res.kind <= cmd.pass2 ? K_RETRY : K_TIMEOUT;
				res.slot <= 4'(idx_q);
				res.out_robot <= robot_m[idx_q];
				res.out_type <= type_m[idx_q];
				res.out_seq <= seq_m[idx_q];
				res.out_command_id <= id_m[idx_q];
				res.retries_remaining <= cmd.pass2 ? rt_m[idx_q] : 2'd0;
			end else if (req_q.opcode == OP_SEND) begin
				if (!sts.send_ok) res.kind <= K_REJECTED;
				else if (!sts.need_ack) res.kind <= K_UNTRACKED;
				else if (cmd.commit) begin
					res.kind <= K_TRACKED;
					res.slot <= 4'(idx_q);
					res.out_command_id <= next_id_q - 32'd1;
					res.retries_remaining <= grant_q;
				end else begin
					res.kind <= K_FULL;
					res.out_command_id <= next_id_q - 32'd1;
				end
			end else if (req_q.opcode == OP_ACK) begin
				if (cmd.ack_free) begin
					res.kind <= K_ACK_HIT;
					res.slot <= 4'(idx_q);
					res.out_robot <= robot_m[idx_q];
					res.out_type <= type_m[idx_q];
					res.out_seq <= seq_m[idx_q];
					res.out_command_id <= id_m[idx_q];
					res.retries_remaining <= rt_m[idx_q];
				end else begin
					res.kind <= K_ACK_MISS;
					res.out_type <= '0;
					res.out_command_id <= req_q.ack_command_id;
				end
			end else begin
				res.kind <= K_IDLE;
				res.out_robot <= '0;
				res.out_type <= '0;
				res.out_seq <= '0;
			end
		end
	end
endmodule

### src/cart_ctrl.sv
// ----------------------------------------------------------------------------
// cart_ctrl
// Sequencer: at most one scan of the slots per request, then reporting.
// ----------------------------------------------------------------------------
module cart_ctrl
	import cart_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_REP1 = 3'd2;
	localparam logic [2:0] S_REP2 = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;
	localparam logic [2:0] S_PREP = 3'd5;

	logic [2:0] state_q, state_d;
	logic ov_q, ov_d, done_q, done_d, pass2_q, pass2_d, any_q, any_d;
	logic busy_out;

	assign busy_out = ov_q && !out_ready;
	assign in_ready = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && !out_ready;
		done_d = done_q;
		pass2_d = pass2_q;
		any_d = any_q;
		cmd = '0;
		cmd.pass2 = pass2_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					cmd.clr_idx = 1'b1;
					pass2_d = 1'b0;
					any_d = 1'b0;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (sts.opcode == OP_SEND && sts.send_ok && sts.need_ack) cmd.do_send = 1'b1;
				state_d = (sts.opcode == OP_POLL || (sts.opcode == OP_ACK && sts.ack_robot_ok) ||
					cmd.do_send) ? S_SCAN : S_OUT;
			end
			S_SCAN: begin
				cmd.classify = (sts.opcode == OP_POLL);
				if (sts.opcode == OP_SEND && sts.free_here) begin
					state_d = S_OUT;
					done_d = 1'b1;
				end else if (sts.opcode == OP_ACK && sts.ack_hit) begin
					state_d = S_OUT;
					done_d = 1'b1;
				end else if (sts.idx_end) begin
					cmd.clr_idx = (sts.opcode == OP_POLL);
					if (sts.opcode == OP_POLL) cmd.step = 1'b1;
					done_d = 1'b0;
					state_d = (sts.opcode == OP_POLL) ? S_REP1 : S_OUT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_OUT: begin
				if (!busy_out) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.commit = done_q && sts.opcode == OP_SEND;
					cmd.ack_free = done_q && sts.opcode == OP_ACK;
					ov_d = 1'b1;
					done_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_REP1, S_REP2: begin
				if ((state_q == S_REP1 ? sts.timed_here : sts.retry_here)) begin
					if (!busy_out) begin
						cmd.emit = 1'b1;
						cmd.emit_kind = 1'b1;
						cmd.emit_last = !sts.any_left || sts.cap_full;
						ov_d = 1'b1;
						any_d = 1'b1;
						if (cmd.emit_last) state_d = S_IDLE;
						else if (sts.idx_end) begin
							cmd.clr_idx = 1'b1;
							pass2_d = 1'b1;
							state_d = S_REP2;
						end else cmd.step = 1'b1;
					end
				end else if (sts.idx_end) begin
					if (state_q == S_REP1) begin
						cmd.clr_idx = 1'b1;
						pass2_d = 1'b1;
						state_d = S_REP2;
					end else state_d = any_q ? S_IDLE : S_OUT;
				end else cmd.step = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			done_q <= 1'b0;
			pass2_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			done_q <= done_d;
			pass2_q <= pass2_d;
			any_q <= any_d;
		end
	end
endmodule

### src/command_ack_retry_table_top.sv
// ----------------------------------------------------------------------------
// command_ack_retry_table_top
// Retransmission table for commands awaiting acknowledgement.
// ----------------------------------------------------------------------------
// One request at a time. A send that needs an ack searches up to TABLE_SLOTS
// slots for a free entry, an ack the same for its match, and a poll
// classifies every slot, then walks the timeout and retry report passes;
// every result waits in a single output register, so a stalled sink holds
// the sequencer.
module command_ack_retry_table_top
	import cart_pkg::*;
#(
	parameter int TABLE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	cart_if.sink        req_ch,
	cart_if.source      res_ch
);
	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.robot_count <= 8'd8;
			cfg_q.critical_priority <= 8'd2;
			cfg_q.ack_timeout_us <= 24'd250000;
			cfg_q.estop_type_code <= 8'd0;
			cfg_q.stop_type_code <= 8'd1;
			cfg_q.start_type_code <= 8'd8;
			cfg_q.cancel_type_code <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				R_ROBOT_COUNT: cfg_q.robot_count <= cfg_wdata[7:0];
				R_CRIT_PRIO: cfg_q.critical_priority <= cfg_wdata[7:0];
				R_TIMEOUT: cfg_q.ack_timeout_us <= cfg_wdata;
				R_ESTOP: cfg_q.estop_type_code <= cfg_wdata[7:0];
				R_STOP: cfg_q.stop_type_code <= cfg_wdata[7:0];
				R_START: cfg_q.start_type_code <= cfg_wdata[7:0];
				R_CANCEL: cfg_q.cancel_type_code <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	cart_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req_ch.valid), .in_ready(req_ch.ready),
		.out_valid(res_ch.valid), .out_ready(res_ch.ready),
		.sts, .cmd
	);

	cart_datapath #(.SLOTS(TABLE_SLOTS)) u_dp (
		.clk, .arst_n, .cfg(cfg_q), .req(req_ch.data), .cmd, .sts, .res(res_ch.data)
	);
endmodule

### src/cart_checker.sv
// ----------------------------------------------------------------------------
// cart_checker
// Port-level checks of the retry table.
// ----------------------------------------------------------------------------
module cart_checker
	import cart_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input res_t res
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res))
		else $error("result changed while stalled");

	// no request taken while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request accepted with pending result");

	// kinds stay within the code set
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res.kind <= K_IDLE)
		else $error("bad result kind");

	// idle results carry no slot
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res.kind == K_IDLE |-> res.slot == '0 && res.last)
		else $error("bad idle result");
endmodule

bind command_ack_retry_table_top cart_checker u_chk (
	.clk, .arst_n,
	.in_valid(req_ch.valid), .in_ready(req_ch.ready),
	.out_valid(res_ch.valid), .out_ready(res_ch.ready),
	.res(res_ch.data)
);
